// File: src/msbbp_pkg.sv
package msbbp_pkg;

    // input modes
    localparam logic [1:0] MODE_BIT   = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_WORD  = 2'd2;
    localparam logic [1:0] MODE_FLUSH = 2'd3;

    // bit position of an empty, aligned partial byte
    localparam logic [2:0] POS_EMPTY = 3'd7;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // one queued job: an optional leading byte, then an optional 32-bit word
    typedef struct packed {
        logic        pad_vld;
        logic [7:0]  pad;
        logic        word_vld;
        logic [31:0] word;
    } t_entry;

    // back-end progress through the head job
    typedef struct packed {
        logic       pad_done;
        logic [1:0] wcnt;
    } t_back_stat;

endpackage

// File: src/msbbp_if.sv
interface msbbp_in_if;
    import msbbp_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface msbbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: src/msbbp_front.sv
module msbbp_front
    import msbbp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    msbbp_in_if.sink     i_in,
    input  logic         i_q_ready,
    output logic         o_push,
    output t_entry       o_entry
);

    logic [7:0]  r_part, n_part;
    logic [2:0]  r_pos, n_pos;
    logic        accept;
    logic [7:0]  bit_set;
    logic [7:0]  part_m;
    logic [15:0] byte_shift;
    t_entry      ent;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;

    always_comb begin
        bit_set    = 8'd1 << r_pos;
        part_m     = r_part | ((i_in.value == 32'd1) ? bit_set : 8'd0);
        // leftover low bits of a byte move to the top of the next partial byte
        byte_shift = {8'd0, i_in.value[7:0]} << ({1'b0, r_pos} + 4'd1);
        ent        = '0;
        n_part     = r_part;
        n_pos      = r_pos;
        case (i_in.mode)
            MODE_BIT: begin
                if (r_pos == 3'd0) begin
                    ent.pad_vld = 1'b1;
                    ent.pad     = part_m;
                    n_part      = 8'd0;
                    n_pos       = POS_EMPTY;
                end else begin
                    n_part = part_m;
                    n_pos  = r_pos - 3'd1;
                end
            end
            MODE_BYTE: begin
                ent.pad_vld = 1'b1;
                ent.pad     = r_part | (i_in.value[7:0] >> (POS_EMPTY - r_pos));
                n_part      = byte_shift[7:0];
            end
            MODE_WORD: begin
                ent.pad_vld  = (r_pos != POS_EMPTY);
                ent.pad      = r_part;
                ent.word_vld = 1'b1;
                ent.word     = i_in.value;
                n_part       = 8'd0;
                n_pos        = POS_EMPTY;
            end
            default: begin
                ent.pad_vld = (r_pos != POS_EMPTY);
                ent.pad     = r_part;
                n_part      = 8'd0;
                n_pos       = POS_EMPTY;
            end
        endcase
    end

    assign o_entry = ent;
    assign o_push  = accept && (ent.pad_vld || ent.word_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= 8'd0;
            r_pos  <= POS_EMPTY;
        end else if (accept) begin
            r_part <= n_part;
            r_pos  <= n_pos;
        end
    end

endmodule

// File: src/msbbp_queue.sv
module msbbp_queue
    import msbbp_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_vld,
    output t_entry o_head,
    output logic [$clog2(P_DEPTH+1)-1:0] o_count
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    t_entry        r_mem [P_DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_vld   = (r_cnt != '0);
    assign o_head  = r_mem[r_rptr];
    assign o_count = r_cnt;
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: src/msbbp_back.sv
module msbbp_back
    import msbbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_entry      i_head,
    output logic        o_pop,
    output t_back_stat  o_stat,
    msbbp_out_if.source o_out
);

    logic       r_vld;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_pad_done;
    logic [1:0] r_wcnt;
    logic       load;
    logic       use_pad;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign load    = i_vld && (!r_vld || o_out.ready);
    assign use_pad = i_head.pad_vld && !r_pad_done;

    always_comb begin
        if (use_pad) begin
            cur_byte = i_head.pad;
            cur_last = !i_head.word_vld;
        end else begin
            cur_byte = i_head.word[{r_wcnt, 3'b000} +: 8];
            cur_last = (r_wcnt == 2'd3);
        end
    end

    assign o_pop           = load && cur_last;
    assign o_stat.pad_done = r_pad_done;
    assign o_stat.wcnt     = r_wcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_pad_done <= 1'b0;
            r_wcnt     <= 2'd0;
        end else begin
            if (load) begin
                r_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_vld <= 1'b0;
            end
            if (load) begin
                if (cur_last) begin
                    r_pad_done <= 1'b0;
                    r_wcnt     <= 2'd0;
                end else if (use_pad) begin
                    r_pad_done <= 1'b1;
                end else begin
                    r_wcnt <= r_wcnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_last <= cur_last;
        end
    end

    assign o_out.valid       = r_vld;
    assign o_out.out_byte    = r_byte;
    assign o_out.last_of_run = r_last;

endmodule

// File: src/msb_first_bit_packer_top.sv
// channel | dir | payload                    | beats per item
// i_in    | in  | mode[1:0], value[31:0]     | 1
// o_out   | out | out_byte[7:0], last_of_run | 0 to 5
//
// one input beat is taken per cycle while the job queue has room
// bit and byte beats give at most one output beat: one per cycle while o_out is ready
// a word beat gives four or five output beats, one per cycle while o_out is ready
// output register lets a new beat enter while a finished byte still waits
// reset (synchronous, active low) empties the partial byte, the queue and the output
// back pressure on o_out fills the queue, then drops i_in.ready
module msb_first_bit_packer_top
    import msbbp_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msbbp_in_if.sink     i_in,
    msbbp_out_if.source  o_out
);

    // front to queue
    logic       push;
    t_entry     push_entry;
    logic       q_ready;

    // queue to back
    logic       q_vld;
    t_entry     q_head;
    logic       pop;
    logic [$clog2(P_DEPTH+1)-1:0] q_count;
    t_back_stat back_stat;

    // front: tracks the partial byte and turns each beat that yields bytes into a job
    msbbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    // short job queue so front and back stall independently
    msbbp_queue #(
        .P_DEPTH (P_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_head  (q_head),
        .o_count (q_count)
    );

    // back: walks the head job byte by byte into the output register
    msbbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_head  (q_head),
        .o_pop   (pop),
        .o_stat  (back_stat),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // queue never holds more jobs than it has room for
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= ($clog2(P_DEPTH+1))'(P_DEPTH))
        else $error("job queue count beyond depth");

    // a job in the queue always has at least one byte to give
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (push_entry.pad_vld || push_entry.word_vld))
        else $error("empty job pushed");

    // mid-word progress only exists on a queued word job
    a_word_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_stat.wcnt != 2'd0) |-> (q_vld && q_head.word_vld))
        else $error("word byte count without word job");

    // a sent leading byte only exists on a queued job that also carries a word
    a_pad_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.pad_done |-> (q_vld && q_head.pad_vld && q_head.word_vld))
        else $error("leading byte marked sent on wrong job");
`endif

endmodule

// File: bench/msbbp_checker.sv
`timescale 1ns / 1ps

// watches both channels, packs accepted beats into expected bytes and
// compares every output beat against the oldest one still waiting
module msbbp_checker
    import msbbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    msbbp_in_if     i_in_mon,
    msbbp_out_if    i_out_mon,
    output int      o_fail_count,
    output int      o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_packed_byte;

    t_packed_byte expected_bytes[$];
    logic [7:0]   acc_bits;
    logic [2:0]   fill_pos;

    function void queue_byte(input logic [7:0] data);
        expected_bytes.push_back('{data: data, last: 1'b0});
    endfunction

    function void pack_one_bit(input logic one);
        if (one)
            acc_bits[fill_pos] = 1'b1;
        if (fill_pos == 3'd0) begin
            queue_byte(acc_bits);
            acc_bits = '0;
            fill_pos = POS_EMPTY;
        end else begin
            fill_pos = fill_pos - 3'd1;
        end
    endfunction

    function void pad_partial();
        if (fill_pos != POS_EMPTY) begin
            queue_byte(acc_bits);
            acc_bits = '0;
            fill_pos = POS_EMPTY;
        end
    endfunction

    function void pack_beat(input logic [1:0] mode, input logic [31:0] value);
        int before_cnt;
        before_cnt = expected_bytes.size();
        case (mode)
            MODE_BIT: begin
                pack_one_bit(value == 32'd1);
            end
            MODE_BYTE: begin
                if (fill_pos == POS_EMPTY) begin
                    queue_byte(value[7:0]);
                end else begin
                    for (int i = 7; i >= 0; i--)
                        pack_one_bit(value[i]);
                end
            end
            MODE_WORD: begin
                pad_partial();
                queue_byte(value[7:0]);
                queue_byte(value[15:8]);
                queue_byte(value[23:16]);
                queue_byte(value[31:24]);
            end
            default: begin
                pad_partial();
            end
        endcase
        // final byte of this beat closes the run
        if (expected_bytes.size() > before_cnt)
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_packed_byte want;
        if (!i_rst_n) begin
            acc_bits = '0;
            fill_pos = POS_EMPTY;
            expected_bytes.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                pack_beat(i_in_mon.mode, i_in_mon.value);
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected beat, actual byte %02h last %0b", $time,
                             i_out_mon.out_byte, i_out_mon.last_of_run);
                    o_fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_mon.out_byte !== want.data) begin
                        $display("%0t: out_byte mismatch, expected %02h actual %02h", $time,
                                 want.data, i_out_mon.out_byte);
                        o_fail_count++;
                    end
                    if (i_out_mon.last_of_run !== want.last) begin
                        $display("%0t: last_of_run mismatch, expected %0b actual %0b", $time,
                                 want.last, i_out_mon.last_of_run);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

// stimulus and verdict for the msb-first bit packer; all prediction and
// comparison lives in the checker instantiated next to the block
module tb;
    import msbbp_pkg::*;

    // far above the slowest legal run: ~350 beats, up to five bytes each,
    // two long receiver hold-offs and heavy random idling on both sides
    localparam int CYCLE_LIMIT  = 200000;
    // length of the deliberate receiver hold-off
    localparam int STALL_CYCLES = 400;

    logic i_clk;
    logic i_rst_n;

    msbbp_in_if  in_ch ();
    msbbp_out_if out_ch ();

    int fail_count;
    int pending_bytes;

    // idle rates in percent, changed per phase by the stimulus process
    int src_idle_pct;
    int sink_idle_pct;

    // hold-off requests from the stimulus side, served by the receiver process
    int holds_asked;

    msb_first_bit_packer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    msbbp_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_bytes)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: a run that never drains ends here
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("** msb_first_bit_packer_top: FAILED **");
        $finish;
    end

    // receiver side: random back pressure, plus a long hold-off on request
    // so the job queue fills and the block drops its input ready
    initial begin : sink_side
        int holds_done;
        int hold_left;
        holds_done = 0;
        hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holds_done != holds_asked) begin
                holds_done++;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // offer one beat, with a random number of idle cycles in front of it,
    // and return at the edge where it is taken
    task automatic send_beat(input logic [1:0] mode, input logic [31:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= mode;
        in_ch.value <= value;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
    endtask

    // random mix: mostly bits and bytes as in a code stream, words and
    // flushes often enough to land on every fill level of the partial byte
    task automatic send_random(input int count);
        logic [1:0]  mode;
        logic [31:0] value;
        int          pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                mode = MODE_BIT;
                // occasionally a value that is neither 0 nor 1
                if ($urandom_range(9) == 0)
                    value = $urandom;
                else
                    value = {31'd0, 1'($urandom_range(1))};
            end else if (pick < 75) begin
                mode  = MODE_BYTE;
                // upper bits are junk the block must ignore
                value = ($urandom_range(3) == 0) ? $urandom : {24'd0, 8'($urandom)};
            end else if (pick < 87) begin
                mode  = MODE_WORD;
                value = $urandom;
            end else begin
                mode  = MODE_FLUSH;
                value = $urandom;
            end
            send_beat(mode, value);
        end
    endtask

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.mode    <= MODE_BIT;
        in_ch.value   <= '0;
        i_rst_n       <= 1'b0;
        holds_asked   = 0;
        src_idle_pct  = 19;
        sink_idle_pct = 45;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: aligned byte pass-through, ignored upper byte bits
        send_beat(MODE_BYTE, 32'h0000_0000);
        send_beat(MODE_BYTE, 32'h0000_00ff);
        send_beat(MODE_BYTE, 32'hffff_ff5a);
        // aligned word and aligned flush: no padding byte, flush gives nothing
        send_beat(MODE_WORD, 32'h0000_0000);
        send_beat(MODE_WORD, 32'hffff_ffff);
        send_beat(MODE_FLUSH, 32'h0000_0000);
        // bit values: only exactly one sets the bit
        send_beat(MODE_BIT, 32'h0000_0001);
        send_beat(MODE_BIT, 32'h0000_0000);
        send_beat(MODE_BIT, 32'h0000_0002);
        send_beat(MODE_BIT, 32'hffff_ffff);
        send_beat(MODE_BIT, 32'h8000_0001);
        // byte straddling two output bytes
        send_beat(MODE_BYTE, 32'hffff_ffa5);
        // partial flush, padded with zeros
        send_beat(MODE_FLUSH, 32'hffff_ffff);
        // partial byte in front of a word: five bytes in one run
        send_beat(MODE_BIT, 32'h0000_0001);
        send_beat(MODE_WORD, 32'h1234_5678);
        // eight single bits complete a byte, all ones
        repeat (8) send_beat(MODE_BIT, 32'h0000_0001);
        // seven bits then a byte: the byte's first bit completes the partial byte
        repeat (7) send_beat(MODE_BIT, 32'h0000_0000);
        send_beat(MODE_BYTE, 32'h0000_00ff);
        send_beat(MODE_FLUSH, 32'h0000_0000);

        // phase one: sender idles lightly, receiver heavily, with a long hold-off
        holds_asked++;
        send_random(110);

        // phase two: roles swapped
        src_idle_pct  = 45;
        sink_idle_pct = 19;
        send_random(110);

        // phase three: back to back on both sides, one more hold-off
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random(40);
        holds_asked++;
        send_random(70);

        in_ch.valid <= 1'b0;

        // let the checker see the last accepted beat, then drain
        @(posedge i_clk);
        while (pending_bytes != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0)
            $display("** msb_first_bit_packer_top: PASSED **");
        else
            $display("** msb_first_bit_packer_top: FAILED **");
        $finish;
    end

endmodule
